// File: src/kts_pkg.sv
package kts_pkg;

	localparam int LINE_BITS_DEF   = 32;
	localparam int COLUMN_BITS_DEF = 16;

	// fixed widths of the token fields
	localparam int TOK_LINE_W = 32;
	localparam int TOK_COL_W  = 16;
	localparam int PROG_W     = 3;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_COMMENT = 2'd1,
		MODE_MATCH   = 2'd2,
		MODE_DONE    = 2'd3
	} scan_mode_t;

	localparam logic [3:0] KIND_I       = 4'd0;
	localparam logic [3:0] KIND_USE     = 4'd1;
	localparam logic [3:0] KIND_ARCH    = 4'd2;
	localparam logic [3:0] KIND_LINUX   = 4'd3;
	localparam logic [3:0] KIND_BTW     = 4'd4;
	localparam logic [3:0] KIND_BY      = 4'd5;
	localparam logic [3:0] KIND_THE     = 4'd6;
	localparam logic [3:0] KIND_WAY     = 4'd7;
	localparam logic [3:0] KIND_GENTOO  = 4'd8;
	localparam logic [3:0] KIND_INVALID = 4'd9;
	localparam logic [3:0] KIND_END     = 4'd10;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	typedef struct packed {
		logic [3:0]            kind;
		logic [TOK_LINE_W-1:0] line;
		logic [TOK_COL_W-1:0]  column;
		logic                  last;
	} tok_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] kind;
	} first_t;

	function automatic first_t kw_first(input logic [7:0] b);
		first_t r;
		r.hit  = 1'b1;
		r.kind = KIND_I;
		unique case (b)
			"i":     r.kind = KIND_I;
			"u":     r.kind = KIND_USE;
			"a":     r.kind = KIND_ARCH;
			"l":     r.kind = KIND_LINUX;
			"b":     r.kind = KIND_BTW;
			"t":     r.kind = KIND_THE;
			"w":     r.kind = KIND_WAY;
			"g":     r.kind = KIND_GENTOO;
			default: r.hit  = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [PROG_W-1:0] suffix_len(input logic [3:0] k);
		logic [PROG_W-1:0] r;
		unique case (k)
			KIND_USE:    r = 3'd2;
			KIND_ARCH:   r = 3'd3;
			KIND_LINUX:  r = 3'd4;
			KIND_BTW:    r = 3'd2;
			KIND_THE:    r = 3'd2;
			KIND_WAY:    r = 3'd2;
			KIND_GENTOO: r = 3'd5;
			default:     r = 3'd0;
		endcase
		return r;
	endfunction

	// expected letter at position p of the keyword's remaining suffix
	function automatic logic [7:0] suffix_char(input logic [3:0] k, input logic [PROG_W-1:0] p);
		logic [7:0] r;
		r = 8'h00;
		unique case (k)
			KIND_USE:    r = (p == 3'd0) ? "s" : "e";
			KIND_ARCH:   r = (p == 3'd0) ? "r" : (p == 3'd1) ? "c" : "h";
			KIND_LINUX:  r = (p == 3'd0) ? "i" : (p == 3'd1) ? "n" :
			                 (p == 3'd2) ? "u" : "x";
			KIND_BTW:    r = (p == 3'd0) ? "t" : "w";
			KIND_THE:    r = (p == 3'd0) ? "h" : "e";
			KIND_WAY:    r = (p == 3'd0) ? "a" : "y";
			KIND_GENTOO: r = (p == 3'd0) ? "e" : (p == 3'd1) ? "n" :
			                 (p == 3'd2) ? "t" : "o";
			default:     r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// File: src/keyword_token_scanner_core.sv
// channel | handshake          | payload
// src     | src_valid/src_stall | source_byte, end_of_stream
// tok     | tok_valid/tok_stall | token_kind, token_line, token_column, last_of_run
//
// one source item per cycle while tok_stall is low and each item yields at most one token;
// an item that yields two tokens holds the input while the second drains.
// item path: input register, scan logic, two-slot token register.
// arst_n clears the scan state, counters (line 1, column 0) and all valid flags.
// src_stall rises only while the input register is full and the token slots are busy.
module keyword_token_scanner_core #(
	parameter int LINE_BITS   = kts_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = kts_pkg::COLUMN_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              src_valid,
	output logic                              src_stall,
	input  logic [7:0]                        source_byte,
	input  logic                              end_of_stream,
	output logic                              tok_valid,
	input  logic                              tok_stall,
	output logic [3:0]                        token_kind,
	output logic [kts_pkg::TOK_LINE_W-1:0]    token_line,
	output logic [kts_pkg::TOK_COL_W-1:0]     token_column,
	output logic                              last_of_run
);
	import kts_pkg::*;

	localparam int LW = (LINE_BITS > TOK_LINE_W) ? LINE_BITS : TOK_LINE_W;
	localparam int CW = (COLUMN_BITS > TOK_COL_W) ? COLUMN_BITS : TOK_COL_W;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       go;

	// scan state
	scan_mode_t             mode_q, mode_n;
	logic [PROG_W-1:0]      prog_q, prog_n;
	logic [3:0]             kind_q, kind_n;
	logic [LINE_BITS-1:0]   sline_q, sline_n, line_q, line_n, line_inc;
	logic [COLUMN_BITS-1:0] scol_q, scol_n, col_q, col_n, col1, col2;

	// token slots
	tok_t       slot0_q, slot1_q, tok_a, tok_b;
	logic [1:0] cnt_q, n_tok;
	logic       room, out_fire;

	logic   is_nl, is_sp, is_semi, by_hit, suf_hit, idle_emit, token_char;
	logic [PROG_W-1:0] slen, prog_inc;
	first_t first;

	function automatic logic [TOK_LINE_W-1:0] to_line(input logic [LINE_BITS-1:0] x);
		logic [LW-1:0] w;
		w = LW'(x);
		return w[TOK_LINE_W-1:0];
	endfunction

	function automatic logic [TOK_COL_W-1:0] to_col(input logic [COLUMN_BITS-1:0] x);
		logic [CW-1:0] w;
		w = CW'(x);
		return w[TOK_COL_W-1:0];
	endfunction

	function automatic tok_t mk_tok(input logic [3:0] k, input logic [LINE_BITS-1:0] l,
	                                input logic [COLUMN_BITS-1:0] c);
		tok_t t;
		t.kind   = k;
		t.line   = to_line(l);
		t.column = to_col(c);
		t.last   = 1'b0;
		return t;
	endfunction

	assign room      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !tok_stall);
	assign go        = valid_s1 && room;
	assign src_stall = valid_s1 && !room;
	assign out_fire  = tok_valid && !tok_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			byte_s1 <= source_byte;
			eos_s1  <= end_of_stream;
		end
	end

	// byte classes and keyword match
	assign is_nl     = (byte_s1 == CH_NL);
	assign is_semi   = (byte_s1 == CH_SEMI);
	assign is_sp     = (byte_s1 == CH_TAB) || is_nl || (byte_s1 == CH_CR) || (byte_s1 == CH_SPACE);
	assign first     = kw_first(byte_s1);
	assign slen      = suffix_len(kind_q);
	assign prog_inc  = prog_q + PROG_W'(1);
	assign by_hit    = (kind_q == KIND_BTW) && (prog_q == '0) && (byte_s1 == "y");
	assign suf_hit   = (prog_q < slen) && (byte_s1 == suffix_char(kind_q, prog_q));
	assign idle_emit = !is_sp && !is_semi && !first.hit;
	assign token_char = !is_sp && !is_semi;

	// saturating counters
	assign line_inc = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);
	assign col1     = (col_q == '1) ? col_q : col_q + COLUMN_BITS'(1);
	assign col2     = (col1 == '1) ? col1 : col1 + COLUMN_BITS'(1);

	// next state
	always_comb begin
		mode_n  = mode_q;
		prog_n  = prog_q;
		kind_n  = kind_q;
		sline_n = sline_q;
		scol_n  = scol_q;
		line_n  = line_q;
		col_n   = col_q;
		if (eos_s1) begin
			unique case (mode_q)
				MODE_COMMENT: begin
					line_n = line_inc;
					col_n  = COLUMN_BITS'(1);
				end
				MODE_MATCH: col_n = col2;
				default:    col_n = col1;
			endcase
			mode_n = MODE_IDLE;
			prog_n = '0;
		end else begin
			unique case (mode_q)
				MODE_COMMENT: begin
					if (is_nl) begin
						line_n = line_inc;
						col_n  = '0;
						mode_n = MODE_IDLE;
					end else begin
						col_n = col1;
					end
				end
				MODE_MATCH: begin
					col_n = col1;
					if (by_hit) begin
						kind_n = KIND_BY;
						prog_n = '0;
						mode_n = MODE_DONE;
					end else if (suf_hit) begin
						prog_n = prog_inc;
						if (prog_inc >= slen) mode_n = MODE_DONE;
					end else begin
						prog_n = '0;
						mode_n = MODE_IDLE;
					end
				end
				default: begin
					// idle, or a finished keyword whose follower is scanned afresh
					mode_n = MODE_IDLE;
					if (mode_q == MODE_DONE) prog_n = '0;
					if (is_nl) begin
						line_n = line_inc;
						col_n  = '0;
					end else begin
						col_n = col1;
						if (is_semi) begin
							mode_n = MODE_COMMENT;
						end else if (!is_sp) begin
							sline_n = line_q;
							scol_n  = col1;
							prog_n  = '0;
							if (first.hit) begin
								kind_n = first.kind;
								mode_n = (first.kind == KIND_I) ? MODE_DONE : MODE_MATCH;
							end
						end
					end
				end
			endcase
		end
	end

	// emitted tokens
	always_comb begin
		n_tok = 2'd0;
		tok_a = mk_tok(KIND_END, line_q, col1);
		tok_b = mk_tok(KIND_END, line_q, col1);
		if (eos_s1) begin
			unique case (mode_q)
				MODE_COMMENT: begin
					tok_a = mk_tok(KIND_END, line_inc, COLUMN_BITS'(1));
					n_tok = 2'd1;
				end
				MODE_MATCH: begin
					tok_a = mk_tok(KIND_INVALID, sline_q, scol_q);
					tok_b = mk_tok(KIND_END, line_q, col2);
					n_tok = 2'd2;
				end
				MODE_DONE: begin
					tok_a = mk_tok(kind_q, sline_q, scol_q);
					n_tok = 2'd2;
				end
				default: n_tok = 2'd1;
			endcase
		end else begin
			unique case (mode_q)
				MODE_MATCH: begin
					if (!by_hit && !suf_hit) begin
						tok_a = mk_tok(KIND_INVALID, sline_q, scol_q);
						n_tok = 2'd1;
					end
				end
				MODE_DONE: begin
					tok_a = mk_tok(token_char ? KIND_INVALID : kind_q, sline_q, scol_q);
					tok_b = mk_tok(KIND_INVALID, line_q, col1);
					n_tok = idle_emit ? 2'd2 : 2'd1;
				end
				MODE_IDLE: begin
					if (idle_emit) begin
						tok_a = mk_tok(KIND_INVALID, line_q, col1);
						n_tok = 2'd1;
					end
				end
				default: n_tok = 2'd0;
			endcase
		end
		tok_a.last = (n_tok == 2'd1);
		tok_b.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			prog_q  <= '0;
			kind_q  <= KIND_I;
			sline_q <= LINE_BITS'(1);
			scol_q  <= '0;
			line_q  <= LINE_BITS'(1);
			col_q   <= '0;
		end else if (go) begin
			mode_q  <= mode_n;
			prog_q  <= prog_n;
			kind_q  <= kind_n;
			sline_q <= sline_n;
			scol_q  <= scol_n;
			line_q  <= line_n;
			col_q   <= col_n;
		end
	end

	// two-slot result register, slot0 is the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (go && n_tok != 2'd0) begin
			cnt_q <= n_tok;
		end else if (out_fire) begin
			cnt_q <= (cnt_q == 2'd2) ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && n_tok != 2'd0) begin
			slot0_q <= tok_a;
			slot1_q <= tok_b;
		end else if (out_fire && cnt_q == 2'd2) begin
			slot0_q <= slot1_q;
		end
	end

	assign tok_valid    = (cnt_q != 2'd0);
	assign token_kind   = slot0_q.kind;
	assign token_line   = slot0_q.line;
	assign token_column = slot0_q.column;
	assign last_of_run  = slot0_q.last;

endmodule

// File: src/kts_checker.sv
module kts_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           src_valid,
	input logic                           src_stall,
	input logic [7:0]                     source_byte,
	input logic                           end_of_stream,
	input logic                           tok_valid,
	input logic                           tok_stall,
	input logic [3:0]                     token_kind,
	input logic [kts_pkg::TOK_LINE_W-1:0] token_line,
	input logic [kts_pkg::TOK_COL_W-1:0]  token_column,
	input logic                           last_of_run
);
	import kts_pkg::*;

	// a stalled token holds
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(token_kind) && $stable(token_line)
		&& $stable(token_column) && $stable(last_of_run))
		else $error("stalled token changed");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> token_kind <= KIND_END)
		else $error("token kind out of range");

	// end of stream always closes the run of its item
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind == KIND_END |-> last_of_run)
		else $error("end token not last of run");

	// no source item offered and no token backlog: the input cannot stall on the next cycle
	a_no_spurious_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!tok_valid && !src_valid |=> !src_stall)
		else $error("input stalled while empty");

endmodule

bind keyword_token_scanner_core kts_checker u_kts_checker (.*);

// File: tb/sv/keyword_token_checker.sv
`timescale 1ns / 100ps

module keyword_token_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	input  logic        src_stall,
	input  logic [7:0]  source_byte,
	input  logic        end_of_stream,
	input  logic        tok_valid,
	input  logic        tok_stall,
	input  logic [3:0]  token_kind,
	input  logic [31:0] token_line,
	input  logic [15:0] token_column,
	input  logic        last_of_run,
	output int          mismatch_count,
	output int          tokens_outstanding,
	output int          tokens_checked
);
	import kts_pkg::*;

	// letters still to come after the first one, indexed by keyword kind
	string tail_text [9] = '{"", "se", "rch", "inux", "tw", "", "he", "ay", "entoo"};

	kts_pkg::tok_t expected_tokens [$];

	scan_mode_t  sc_mode;
	logic [4:0]  sc_progress;
	logic [3:0]  sc_kind;
	logic [31:0] tok_line0;
	logic [15:0] tok_col0;
	logic [31:0] line_no;
	logic [15:0] col_no;

	function automatic bit is_blank(input logic [7:0] b);
		return b == CH_TAB || b == CH_NL || b == CH_CR || b == CH_SPACE;
	endfunction

	function automatic int tail_len(input logic [3:0] k);
		if (k > KIND_GENTOO)
			return 0;
		return tail_text[k].len();
	endfunction

	function automatic logic [7:0] tail_char(input logic [3:0] k, input int p);
		if (p >= tail_len(k))
			return 8'h00;
		return tail_text[k][p];
	endfunction

	task automatic bump_column();
		if (col_no != 16'hFFFF)
			col_no = col_no + 16'd1;
	endtask

	task automatic next_line();
		if (line_no != 32'hFFFF_FFFF)
			line_no = line_no + 32'd1;
		col_no = 16'd0;
	endtask

	task automatic push_token(input logic [3:0] kind, input logic [31:0] line,
			input logic [15:0] col);
		kts_pkg::tok_t t;
		t.kind   = kind;
		t.line   = line;
		t.column = col;
		t.last   = 1'b0;
		expected_tokens.push_back(t);
	endtask

	// byte seen between tokens
	task automatic scan_fresh(input logic [7:0] b);
		if (b == CH_NL) begin
			next_line();
			return;
		end
		bump_column();
		if (b == CH_SEMI) begin
			sc_mode = MODE_COMMENT;
			return;
		end
		if (is_blank(b))
			return;
		tok_line0   = line_no;
		tok_col0    = col_no;
		sc_progress = 5'd0;
		case (b)
			"i": sc_kind = KIND_I;
			"u": sc_kind = KIND_USE;
			"a": sc_kind = KIND_ARCH;
			"l": sc_kind = KIND_LINUX;
			"b": sc_kind = KIND_BTW;
			"t": sc_kind = KIND_THE;
			"w": sc_kind = KIND_WAY;
			"g": sc_kind = KIND_GENTOO;
			default: begin
				push_token(KIND_INVALID, tok_line0, tok_col0);
				return;
			end
		endcase
		sc_mode = (tail_len(sc_kind) == 0) ? MODE_DONE : MODE_MATCH;
	endtask

	task automatic scan_letter(input logic [7:0] b);
		bump_column();
		if (sc_kind == KIND_BTW && sc_progress == 5'd0 && b == "y") begin
			sc_kind     = KIND_BY;
			sc_progress = 5'd0;
			sc_mode     = MODE_DONE;
		end else if (sc_progress < tail_len(sc_kind) && b == tail_char(sc_kind, sc_progress)) begin
			sc_progress = sc_progress + 5'd1;
			if (sc_progress >= tail_len(sc_kind))
				sc_mode = MODE_DONE;
		end else begin
			// breaking byte is swallowed
			push_token(KIND_INVALID, tok_line0, tok_col0);
			sc_mode     = MODE_IDLE;
			sc_progress = 5'd0;
		end
	endtask

	task automatic predict_tokens(input logic [7:0] b, input logic eos);
		int prior_count;
		kts_pkg::tok_t t;
		prior_count = expected_tokens.size();
		if (eos) begin
			case (sc_mode)
				MODE_COMMENT: begin
					bump_column();
					next_line();
				end
				MODE_MATCH: begin
					bump_column();
					push_token(KIND_INVALID, tok_line0, tok_col0);
				end
				MODE_DONE: push_token(sc_kind, tok_line0, tok_col0);
				default: ;
			endcase
			bump_column();
			push_token(KIND_END, line_no, col_no);
			sc_mode     = MODE_IDLE;
			sc_progress = 5'd0;
		end else begin
			case (sc_mode)
				MODE_COMMENT: begin
					if (b == CH_NL) begin
						next_line();
						sc_mode = MODE_IDLE;
					end else begin
						bump_column();
					end
				end
				MODE_MATCH: scan_letter(b);
				MODE_DONE: begin
					// a token character right after a keyword spoils it and is rescanned
					push_token((!is_blank(b) && b != CH_SEMI) ? KIND_INVALID : sc_kind,
						tok_line0, tok_col0);
					sc_mode     = MODE_IDLE;
					sc_progress = 5'd0;
					scan_fresh(b);
				end
				default: scan_fresh(b);
			endcase
		end
		if (expected_tokens.size() > prior_count) begin
			t = expected_tokens.pop_back();
			t.last = 1'b1;
			expected_tokens.push_back(t);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		kts_pkg::tok_t want;
		if (!arst_n) begin
			sc_mode        = MODE_IDLE;
			sc_progress    = 5'd0;
			sc_kind        = KIND_I;
			tok_line0      = 32'd1;
			tok_col0       = 16'd0;
			line_no        = 32'd1;
			col_no         = 16'd0;
			expected_tokens.delete();
			mismatch_count = 0;
			tokens_checked = 0;
		end else begin
			if (src_valid && !src_stall)
				predict_tokens(source_byte, end_of_stream);
			if (tok_valid && !tok_stall) begin
				tokens_checked++;
				if (expected_tokens.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected token, expected none, actual kind %0d line %0d col %0d",
						$time, token_kind, token_line, token_column);
				end else begin
					want = expected_tokens.pop_front();
					check_field("token_kind", 32'(want.kind), 32'(token_kind));
					check_field("token_line", want.line, token_line);
					check_field("token_column", 32'(want.column), 32'(token_column));
					check_field("last_of_run", 32'(want.last), 32'(last_of_run));
				end
			end
		end
		tokens_outstanding = expected_tokens.size();
	end

endmodule

// File: tb/sv/tb_keyword_token_scanner_core.sv
`timescale 1ns / 100ps

module tb_keyword_token_scanner_core;
	import kts_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	logic [7:0]  source_byte = 8'h00;
	logic        end_of_stream = 1'b0;
	logic        tok_valid;
	logic        tok_stall = 1'b0;
	logic [3:0]  token_kind;
	logic [31:0] token_line;
	logic [15:0] token_column;
	logic        last_of_run;

	int mismatch_count;
	int tokens_outstanding;
	int tokens_checked;

	bit idle_on = 1'b1;
	int items_sent = 0;
	int ends_sent = 0;

	string kw_words [9] = '{"i", "use", "arch", "linux", "btw", "by", "the", "way", "gentoo"};
	string kw_heads = "iualbtwg";

	always #5 clk = ~clk;

	keyword_token_scanner_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.src_valid     (src_valid),
		.src_stall     (src_stall),
		.source_byte   (source_byte),
		.end_of_stream (end_of_stream),
		.tok_valid     (tok_valid),
		.tok_stall     (tok_stall),
		.token_kind    (token_kind),
		.token_line    (token_line),
		.token_column  (token_column),
		.last_of_run   (last_of_run)
	);

	keyword_token_checker u_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.src_valid          (src_valid),
		.src_stall          (src_stall),
		.source_byte        (source_byte),
		.end_of_stream      (end_of_stream),
		.tok_valid          (tok_valid),
		.tok_stall          (tok_stall),
		.token_kind         (token_kind),
		.token_line         (token_line),
		.token_column       (token_column),
		.last_of_run        (last_of_run),
		.mismatch_count     (mismatch_count),
		.tokens_outstanding (tokens_outstanding),
		.tokens_checked     (tokens_checked)
	);

	// token side backpressure in random bursts
	initial begin
		int burst;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 13);
				tok_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				tok_stall <= 1'b0;
			end else begin
				tok_stall <= 1'b0;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_keyword_token_scanner_core: errors");
		$finish;
	end

	task automatic send_item(input logic [7:0] b, input logic eos);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			repeat (gap) begin
				@(negedge clk);
				src_valid <= 1'b0;
			end
		end
		@(negedge clk);
		src_valid     <= 1'b1;
		source_byte   <= b;
		end_of_stream <= eos;
		@(posedge clk);
		while (src_stall !== 1'b0) @(posedge clk);
		items_sent++;
		if (eos)
			ends_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(b, 1'b0);
	endtask

	task automatic send_end();
		// the byte field is don't-care on an end mark
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_separator();
		case ($urandom_range(0, 4))
			0: send_byte(CH_SPACE);
			1: send_byte(CH_TAB);
			2: send_byte(CH_CR);
			3: send_byte(CH_NL);
			default: begin
				send_byte(CH_SEMI);
				send_byte(CH_NL);
			end
		endcase
	endtask

	function automatic logic [7:0] pick_token_char();
		logic [7:0] b;
		if ($urandom_range(0, 1) == 0)
			return kw_heads[$urandom_range(0, kw_heads.len() - 1)];
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_TAB || b == CH_NL || b == CH_CR || b == CH_SPACE || b == CH_SEMI);
		return b;
	endfunction

	// one random phrase: mostly well-formed keywords, some broken ones and noise
	task automatic send_phrase();
		string w;
		int n;
		w = kw_words[$urandom_range(0, 8)];
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
				send_text(w);
				send_separator();
			end
			10, 11: begin
				send_text(w);
				send_byte(pick_token_char());
			end
			12: begin
				if (w.len() > 1)
					w[$urandom_range(1, w.len() - 1)] = 8'($urandom_range(0, 255));
				send_text(w);
				send_separator();
			end
			13: begin
				if (w.len() > 1)
					w = w.substr(0, $urandom_range(0, w.len() - 2));
				send_text(w);
				if ($urandom_range(0, 2) == 0)
					send_end();
				else
					send_separator();
			end
			14: begin
				send_byte(CH_SEMI);
				n = $urandom_range(0, 5);
				repeat (n) send_byte(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 3) == 0)
					send_end();
				else
					send_byte(CH_NL);
			end
			15, 16: begin
				n = $urandom_range(1, 4);
				repeat (n) send_byte(8'($urandom_range(0, 255)));
			end
			17: send_end();
			18: begin
				n = $urandom_range(1, 4);
				repeat (n) send_separator();
			end
			default: begin
				send_text(w);
				send_end();
			end
		endcase
	endtask

	task automatic run_random(input int count);
		int goal;
		goal = items_sent + count;
		while (items_sent < goal)
			send_phrase();
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		send_text("i ");
		send_text("use\n");
		send_text("bx");
		// completed keyword spoiled by a token character: two tokens from one transfer
		send_text("byz");
		send_byte("#");
		send_text(";\n");
		send_end();
		send_text("way");
		send_end();
		send_text("ge");
		send_end();
		send_text(";x");
		send_end();
		send_byte(8'hFF);
		send_byte(8'h00);

		run_random(300);
		idle_on = 1'b0;
		run_random(120);
		idle_on = 1'b1;
		run_random(120);

		// closing stretch runs back to back with no source gaps and no token-side stalls
		idle_on = 1'b0;
		run_random(80);

		@(negedge clk);
		src_valid <= 1'b0;
		while (tokens_outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("run covered %0d source transfers with %0d end marks", items_sent, ends_sent);
		$display("%0d token transfers compared, %0d mismatches", tokens_checked, mismatch_count);
		if (mismatch_count == 0 && tokens_outstanding == 0)
			$display("tb_keyword_token_scanner_core: clean");
		else
			$display("tb_keyword_token_scanner_core: errors");
		$finish;
	end

endmodule

// File: files.f
src/kts_pkg.sv
src/keyword_token_scanner_core.sv
src/kts_checker.sv
tb/sv/keyword_token_checker.sv
tb/sv/tb_keyword_token_scanner_core.sv
